// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/cwf_pkg.sv
package cwf_pkg;

   localparam int MAX_WORDS = 8;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_START_WRITE = 2'd0,
      CMD_WRITE_DATA  = 2'd1,
      CMD_START_READ  = 2'd2,
      CMD_RX_BYTE     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_CRC_ERROR   = 2'd1,
      STATUS_COUNT_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      JOB_START       = 3'd0,
      JOB_WRITE       = 3'd1,
      JOB_RX_WORD     = 3'd2,
      JOB_RX_ERROR    = 3'd3,
      JOB_COUNT_ERROR = 3'd4
   } job_kind_type;

   // One classified item handed from the front end to the back end
   typedef struct packed {
      job_kind_type kind;
      logic [15:0]  word;
      logic         last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Result layout on rsp_tdata, lowest field last
   typedef struct packed {
      logic [3:0]  pad;
      status_type  status;
      logic        rx_valid;
      logic [15:0] rx_word;
      logic        tx_valid;
      logic [7:0]  tx_byte;
   } rsp_data_type;

   // Run one byte's worth of CRC-8 shifts, MSB first
   function automatic logic [7:0] crc8_shift_byte(input logic [7:0] value);
      logic [7:0] crc;
      crc = value;
      for (int b = 0; b < 8; b++) begin
         if (crc[7]) begin
            crc = {crc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[6:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

// File: src/cwf_front.sv
module cwf_front import cwf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  queue_status_type      queue_status,
   output logic                  push,
   output job_type               push_job
);

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_WRITE = 3'b010,
      MODE_READ  = 3'b100
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [3:0]  words_left_ff, words_left_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic [7:0]  low_byte_ff, low_byte_in;
   logic        failed_ff, failed_in;
   logic [7:0]  crc_ff, crc_in;

   command_type command;
   logic [15:0] word;
   logic [3:0]  count;
   logic [7:0]  rx_byte;
   logic        accept;

   // Unpack the request transfer
   assign command = command_type'(req_tuser);
   assign word    = req_tdata[15:0];
   assign count   = req_tdata[19:16];
   assign rx_byte = req_tdata[27:20];

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;

   // Classify the item and advance the frame state
   always_comb begin
      mode_in       = mode_ff;
      words_left_in = words_left_ff;
      byte_pos_in   = byte_pos_ff;
      high_byte_in  = high_byte_ff;
      low_byte_in   = low_byte_ff;
      failed_in     = failed_ff;
      crc_in        = crc_ff;
      push          = 1'b0;
      push_job      = '{kind: JOB_START, word: word, last: 1'b0};
      if (accept) begin
         case (command)
            CMD_START_WRITE, CMD_START_READ: begin
               failed_in   = 1'b0;
               byte_pos_in = 2'd0;
               push        = 1'b1;
               if (count > 4'(MAX_WORDS)) begin
                  mode_in       = MODE_IDLE;
                  words_left_in = 4'd0;
                  push_job.kind = JOB_COUNT_ERROR;
                  push_job.last = 1'b1;
               end else begin
                  words_left_in = count;
                  if (count == 4'd0) begin
                     mode_in = MODE_IDLE;
                  end else if (command == CMD_START_WRITE) begin
                     mode_in = MODE_WRITE;
                  end else begin
                     mode_in = MODE_READ;
                  end
                  push_job.last = (count == 4'd0);
               end
            end
            CMD_WRITE_DATA: begin
               if (mode_ff == MODE_WRITE && words_left_ff != 4'd0) begin
                  words_left_in = words_left_ff - 4'd1;
                  if (words_left_ff == 4'd1) begin
                     mode_in = MODE_IDLE;
                  end
                  push          = 1'b1;
                  push_job.kind = JOB_WRITE;
                  push_job.last = (words_left_ff == 4'd1);
               end
            end
            CMD_RX_BYTE: begin
               if (mode_ff == MODE_READ && !failed_ff && words_left_ff != 4'd0) begin
                  case (byte_pos_ff)
                     2'd0: begin
                        high_byte_in = rx_byte;
                        crc_in       = crc8_shift_byte(CRC_INIT ^ rx_byte);
                        byte_pos_in  = 2'd1;
                     end
                     2'd1: begin
                        low_byte_in = rx_byte;
                        crc_in      = crc8_shift_byte(crc_ff ^ rx_byte);
                        byte_pos_in = 2'd2;
                     end
                     default: begin
                        byte_pos_in   = 2'd0;
                        push          = 1'b1;
                        push_job.word = {high_byte_ff, low_byte_ff};
                        if (crc_ff != rx_byte) begin
                           failed_in     = 1'b1;
                           mode_in       = MODE_IDLE;
                           words_left_in = 4'd0;
                           push_job.kind = JOB_RX_ERROR;
                           push_job.last = 1'b1;
                        end else begin
                           words_left_in = words_left_ff - 4'd1;
                           if (words_left_ff == 4'd1) begin
                              mode_in = MODE_IDLE;
                           end
                           push_job.kind = JOB_RX_WORD;
                           push_job.last = (words_left_ff == 4'd1);
                        end
                     end
                  endcase
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         words_left_ff <= 4'd0;
         byte_pos_ff   <= 2'd0;
         high_byte_ff  <= 8'd0;
         low_byte_ff   <= 8'd0;
         failed_ff     <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         words_left_ff <= words_left_in;
         byte_pos_ff   <= byte_pos_in;
         high_byte_ff  <= high_byte_in;
         low_byte_ff   <= low_byte_in;
         failed_ff     <= failed_in;
      end
   end

   // Running receive CRC, valid only in the middle of a word
   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

endmodule

// File: src/cwf_queue.sv
module cwf_queue import cwf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type queue_status
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign queue_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head               = slot_ff[rd_ptr_ff];

   assign do_push = push && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: src/cwf_back.sv
module cwf_back import cwf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  job_type               head,
   input  queue_status_type      queue_status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic         busy_ff, busy_in;
   job_type      job_ff, job_in;
   logic [1:0]   idx_ff, idx_in;
   logic [7:0]   crc_ff, crc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   job_type      src_job;
   logic [1:0]   src_idx;
   logic [1:0]   final_idx;
   logic         fire;
   logic         final_step;
   rsp_data_type result;
   logic         result_last;
   logic [7:0]   hi;
   logic [7:0]   lo;

   // Take the job in progress, otherwise the queue head
   assign src_job    = busy_ff ? job_ff : head;
   assign src_idx    = busy_ff ? idx_ff : 2'd0;
   assign hi         = src_job.word[15:8];
   assign lo         = src_job.word[7:0];
   assign fire       = (busy_ff || !queue_status.empty) && (!rsp_valid_ff || rsp_tready);
   assign pop        = fire && !busy_ff;
   assign final_step = (src_idx == final_idx);

   // Number of results a job spreads over, less one
   always_comb begin
      case (src_job.kind)
         JOB_START: final_idx = 2'd1;
         JOB_WRITE: final_idx = 2'd2;
         default:   final_idx = 2'd0;
      endcase
   end

   // Build the result for the current step of the job
   always_comb begin
      result      = '0;
      result_last = 1'b0;
      crc_in      = crc_ff;
      case (src_job.kind)
         JOB_START: begin
            result.tx_valid = 1'b1;
            result.tx_byte  = (src_idx == 2'd0) ? hi : lo;
            result_last     = final_step && src_job.last;
         end
         JOB_WRITE: begin
            result.tx_valid = 1'b1;
            case (src_idx)
               2'd0: begin
                  result.tx_byte = hi;
                  if (fire) begin
                     crc_in = crc8_shift_byte(CRC_INIT ^ hi);
                  end
               end
               2'd1: begin
                  result.tx_byte = lo;
                  // Advance the CRC only when the step is taken
                  if (fire) begin
                     crc_in = crc8_shift_byte(crc_ff ^ lo);
                  end
               end
               default: begin
                  result.tx_byte = crc_ff;
               end
            endcase
            result_last = final_step && src_job.last;
         end
         JOB_RX_WORD: begin
            result.rx_word  = src_job.word;
            result.rx_valid = 1'b1;
            result_last     = src_job.last;
         end
         JOB_RX_ERROR: begin
            result.rx_word = src_job.word;
            result.status  = STATUS_CRC_ERROR;
            result_last    = src_job.last;
         end
         JOB_COUNT_ERROR: begin
            result.status = STATUS_COUNT_ERROR;
            result_last   = src_job.last;
         end
         default: begin
            result_last = 1'b0;
         end
      endcase
   end

   // Step the job and load the output register
   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire) begin
         busy_in      = !final_step;
         job_in       = src_job;
         idx_in       = src_idx + 2'd1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
         rsp_last_in  = result_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      crc_ff      <= crc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: src/crc8_word_frame_codec.sv
// Word framing codec for a sensor bus, CRC-8 (poly 0x31, init 0xFF, MSB first).
// Request channel: one item per transfer; req_tuser holds the command
// (start write, write data word, start read, received byte), req_tdata
// holds the word, the word count and the received byte.
// Response channel: one byte to send, one checked received word or one
// error status per transfer; rsp_tlast marks the final result of a frame.
// Each item's results pass through the job queue and the response output
// register, and wait there while the response side is stalled or busy.
// Throughput: a request is taken every cycle while the two-entry job
// queue has room; results leave at one per cycle while rsp_tready is
// high, so a write data word yields three results, a start two and a
// received word or error one. The response output register sets that rate.
// Reset clears the frame state, the job queue and the output register;
// no frame is open afterward.
// When the receiver holds rsp_tready low, the current result stays put,
// the queue fills, and req_tready drops once it is full.
module crc8_word_frame_codec import cwf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // word[15:0], count[19:16], rx_byte[27:20], zero
   input  logic [REQ_USER_W-1:0] req_tuser,  // command[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // tx_byte[7:0], tx_valid[8], rx_word[24:9],
                                             // rx_valid[25], status[27:26], zero
   output logic                  rsp_tlast
);

   queue_status_type queue_status;
   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head;

   cwf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   cwf_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_job     (push_job),
      .pop          (pop),
      .head         (head),
      .queue_status (queue_status)
   );

   cwf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// File: src/cwf_checker.sv
`include "assert_macros.svh"

module cwf_checker import cwf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   rsp_data_type rsp_fields;

   assign rsp_fields = rsp_data_type'(rsp_tdata);

   // A stalled result holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Nothing is offered right after reset
   `ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid)

   // Any error ends the frame
   `ASSERT_SAME(a_error_last, clock, reset,
      rsp_tvalid && rsp_fields.status != STATUS_OK, rsp_tlast)

   // A result is a transmit byte or a received word, never both
   `ASSERT_SAME(a_one_kind, clock, reset, rsp_tvalid,
      !(rsp_fields.tx_valid && rsp_fields.rx_valid))

   // A checked word carries ok status and no error result sends a byte
   `ASSERT_SAME(a_status_kind, clock, reset,
      rsp_tvalid && (rsp_fields.rx_valid || rsp_fields.tx_valid),
      rsp_fields.status == STATUS_OK)

endmodule

bind crc8_word_frame_codec cwf_checker u_checker (.*);

// File: dv/tb_crc8_word_frame_codec.sv
`timescale 1ns / 100ps

module tb_crc8_word_frame_codec;
   import cwf_pkg::*;

   localparam int ITEM_TARGET  = 480;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX   = 10;

   typedef enum logic [1:0] {
      FRAME_IDLE  = 2'd0,
      FRAME_WRITE = 2'd1,
      FRAME_READ  = 2'd2
   } frame_mode_type;

   // One result as seen on the response channel
   typedef struct packed {
      logic        last;
      status_type  status;
      logic        rx_valid;
      logic [15:0] rx_word;
      logic        tx_valid;
      logic [7:0]  tx_byte;
   } frame_result_type;

   // One request row; typed_n < 0 leaves the expectation to the predictor
   typedef struct {
      command_type                cmd;
      logic [15:0]                word;
      logic [3:0]                 count;
      logic [7:0]                 rx;
      int                         typed_n;
      frame_result_type [2:0]     typed;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Predictor state
   frame_mode_type   pred_mode;
   logic [3:0]       pred_words_left;
   logic [1:0]       pred_byte_pos;
   logic [7:0]       pred_high_byte;
   logic [7:0]       pred_low_byte;
   logic             pred_failed;
   frame_result_type step_out[$];
   frame_result_type predicted_outputs[$];
   stim_row_type     directed_rows[$];

   bit sender_idles;
   bit receiver_idles;
   int stall_left;
   int failures;
   int effective_items;
   int results_checked;
   int crc_error_results;
   int write_frames;
   int read_frames;
   int cycle_count;

   crc8_word_frame_codec i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // CRC-8 over the word, one bit at a time, MSB first
   function automatic logic [7:0] crc_of_word(input logic [15:0] w);
      logic [7:0] c;
      logic       fb;
      c = CRC_INIT;
      for (int i = 15; i >= 0; i--) begin
         fb = c[7] ^ w[i];
         c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   function automatic frame_result_type tx_result(input logic [7:0] b, input logic last);
      frame_result_type r;
      r          = '0;
      r.tx_byte  = b;
      r.tx_valid = 1'b1;
      r.last     = last;
      return r;
   endfunction

   function automatic frame_result_type rx_result(input logic [15:0] w, input logic valid,
                                                  input status_type st, input logic last);
      frame_result_type r;
      r          = '0;
      r.rx_word  = w;
      r.rx_valid = valid;
      r.status   = st;
      r.last     = last;
      return r;
   endfunction

   function automatic stim_row_type item_row(input command_type cmd,
                                             input logic [15:0] word = '0,
                                             input logic [3:0] count = '0,
                                             input logic [7:0] rx = '0, input int typed_n = -1,
                                             input frame_result_type r0 = '0,
                                             input frame_result_type r1 = '0,
                                             input frame_result_type r2 = '0);
      stim_row_type s;
      s.cmd     = cmd;
      s.word    = word;
      s.count   = count;
      s.rx      = rx;
      s.typed_n = typed_n;
      s.typed   = {r2, r1, r0};
      return s;
   endfunction

   // Advance the framing state for one item; fill step_out, return 1 unless ignored
   function automatic bit predict_framing(input stim_row_type s);
      logic [15:0] w;
      logic        fin;
      step_out.delete();
      case (s.cmd)
         CMD_START_WRITE, CMD_START_READ: begin
            pred_failed   = 1'b0;
            pred_byte_pos = '0;
            if (s.count > MAX_WORDS) begin
               pred_mode       = FRAME_IDLE;
               pred_words_left = '0;
               step_out.push_back(rx_result('0, 1'b0, STATUS_COUNT_ERROR, 1'b1));
            end else begin
               pred_words_left = s.count;
               if (s.count == 0) begin
                  pred_mode = FRAME_IDLE;
               end else begin
                  pred_mode = (s.cmd == CMD_START_WRITE) ? FRAME_WRITE : FRAME_READ;
               end
               step_out.push_back(tx_result(s.word[15:8], 1'b0));
               step_out.push_back(tx_result(s.word[7:0], s.count == 0));
            end
            return 1'b1;
         end
         CMD_WRITE_DATA: begin
            if (pred_mode != FRAME_WRITE || pred_words_left == 0) return 1'b0;
            pred_words_left = pred_words_left - 1'b1;
            fin = (pred_words_left == 0);
            if (fin) pred_mode = FRAME_IDLE;
            step_out.push_back(tx_result(s.word[15:8], 1'b0));
            step_out.push_back(tx_result(s.word[7:0], 1'b0));
            step_out.push_back(tx_result(crc_of_word(s.word), fin));
            return 1'b1;
         end
         default: begin
            if (pred_mode != FRAME_READ || pred_failed || pred_words_left == 0) return 1'b0;
            if (pred_byte_pos == 0) begin
               pred_high_byte = s.rx;
               pred_byte_pos  = 2'd1;
            end else if (pred_byte_pos == 1) begin
               pred_low_byte = s.rx;
               pred_byte_pos = 2'd2;
            end else begin
               pred_byte_pos = '0;
               w = {pred_high_byte, pred_low_byte};
               if (crc_of_word(w) != s.rx) begin
                  pred_failed     = 1'b1;
                  pred_mode       = FRAME_IDLE;
                  pred_words_left = '0;
                  step_out.push_back(rx_result(w, 1'b0, STATUS_CRC_ERROR, 1'b1));
               end else begin
                  pred_words_left = pred_words_left - 1'b1;
                  if (pred_words_left == 0) pred_mode = FRAME_IDLE;
                  step_out.push_back(rx_result(w, 1'b1, STATUS_OK, pred_words_left == 0));
               end
            end
            return 1'b1;
         end
      endcase
   endfunction

   task automatic note_failure(input string what, input frame_result_type want,
                               input frame_result_type got);
      failures++;
      if (failures <= REPORT_MAX) begin
         $display("%s at cycle %0d", what, cycle_count);
         $display("  expected tx %h/%b rx %h/%b status %0d last %b",
                  want.tx_byte, want.tx_valid, want.rx_word, want.rx_valid,
                  want.status, want.last);
         $display("  actual   tx %h/%b rx %h/%b status %0d last %b",
                  got.tx_byte, got.tx_valid, got.rx_word, got.rx_valid,
                  got.status, got.last);
      end
   endtask

   // Offer one request, wait for its transfer, then queue what it should produce
   task automatic send_item(input stim_row_type s);
      int  gap;
      bit  took;
      @(negedge clock);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap        = $urandom_range(1, 6);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, s.rx, s.count, s.word};
      req_tuser  = s.cmd;
      do @(posedge clock); while (!req_tready);
      took = predict_framing(s);
      if (took) effective_items++;
      if (s.typed_n < 0) begin
         foreach (step_out[i]) predicted_outputs.push_back(step_out[i]);
      end else begin
         for (int i = 0; i < s.typed_n; i++) predicted_outputs.push_back(s.typed[i]);
      end
   endtask

   // Hold off the sender until every queued result has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_count();
      if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(1, MAX_WORDS));
   endfunction

   task automatic run_write_frame();
      logic [3:0] n;
      int         stop_at;
      n = pick_count();
      write_frames++;
      send_item(item_row(CMD_START_WRITE, 16'($urandom), n));
      stop_at = n;
      if (n > MAX_WORDS) stop_at = $urandom_range(0, 2);
      else if ($urandom_range(0, 9) == 0) stop_at = $urandom_range(0, n);
      else if ($urandom_range(0, 9) == 0) stop_at = n + 1;
      for (int i = 0; i < stop_at; i++) begin
         send_item(item_row(CMD_WRITE_DATA, 16'($urandom)));
      end
   endtask

   task automatic run_read_frame();
      logic [3:0]  n;
      logic [15:0] w;
      logic [7:0]  bytes[3];
      int          stop_at;
      n = pick_count();
      read_frames++;
      send_item(item_row(CMD_START_READ, 16'($urandom), n));
      stop_at = n;
      if (n > MAX_WORDS) stop_at = 1;
      else if ($urandom_range(0, 9) == 0) stop_at = $urandom_range(0, n);
      else if ($urandom_range(0, 9) == 0) stop_at = n + 1;
      for (int i = 0; i < stop_at; i++) begin
         w        = 16'($urandom);
         bytes[0] = w[15:8];
         bytes[1] = w[7:0];
         bytes[2] = crc_of_word(w);
         // corrupt one byte now and then to end the frame early
         if ($urandom_range(0, 14) == 0) begin
            bytes[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
         end
         for (int k = 0; k < 3; k++) send_item(item_row(CMD_RX_BYTE, '0, '0, bytes[k]));
      end
   endtask

   // Stray items of any kind with random fields
   task automatic run_noise();
      int n;
      n = $urandom_range(1, 3);
      repeat (n) begin
         send_item(item_row(command_type'($urandom_range(0, 3)), 16'($urandom),
                            4'($urandom), 8'($urandom)));
      end
   endtask

   // Receiver side: random stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Check every result transfer against the oldest prediction
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tx_byte  = rsp_tdata[7:0];
         got.tx_valid = rsp_tdata[8];
         got.rx_word  = rsp_tdata[24:9];
         got.rx_valid = rsp_tdata[25];
         got.status   = status_type'(rsp_tdata[27:26]);
         got.last     = rsp_tlast;
         results_checked++;
         if (got.status == STATUS_CRC_ERROR) crc_error_results++;
         if (predicted_outputs.size() == 0) begin
            note_failure("unexpected result", '0, got);
         end else begin
            want = predicted_outputs.pop_front();
            if (got.tx_byte !== want.tx_byte || got.tx_valid !== want.tx_valid ||
                got.rx_word !== want.rx_word || got.rx_valid !== want.rx_valid ||
                got.status !== want.status || got.last !== want.last ||
                rsp_tdata[31:28] !== 4'b0) begin
               note_failure("result mismatch", want, got);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", predicted_outputs.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = CMD_START_WRITE;
      rsp_tready      = 1'b0;
      stall_left      = 0;
      sender_idles    = 1'b1;
      receiver_idles  = 1'b1;
      pred_mode       = FRAME_IDLE;
      pred_words_left = '0;
      pred_byte_pos   = '0;
      pred_high_byte  = '0;
      pred_low_byte   = '0;
      pred_failed     = 1'b0;

      // Directed part: stray items after reset, count limits, empty frame,
      // a known CRC (0xBEEF -> 0x92) both ways, a mismatch, a restart mid-frame
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'hA5, 0));
      directed_rows.push_back(item_row(CMD_WRITE_DATA, 16'h1234, '0, '0, 0));
      directed_rows.push_back(item_row(CMD_START_WRITE, 16'h3608, 4'd9, '0, 1,
                              rx_result('0, 1'b0, STATUS_COUNT_ERROR, 1'b1)));
      directed_rows.push_back(item_row(CMD_START_READ, 16'hFFFF, 4'd15, 8'hFF, 1,
                              rx_result('0, 1'b0, STATUS_COUNT_ERROR, 1'b1)));
      directed_rows.push_back(item_row(CMD_START_WRITE, 16'h0000, 4'd0, '0, 2,
                              tx_result(8'h00, 1'b0), tx_result(8'h00, 1'b1)));
      directed_rows.push_back(item_row(CMD_START_WRITE, 16'h2003, 4'd2));
      directed_rows.push_back(item_row(CMD_WRITE_DATA, 16'hBEEF, '0, '0, 3,
                              tx_result(8'hBE, 1'b0), tx_result(8'hEF, 1'b0),
                              tx_result(8'h92, 1'b0)));
      directed_rows.push_back(item_row(CMD_WRITE_DATA, 16'hFFFF));
      directed_rows.push_back(item_row(CMD_WRITE_DATA, 16'h0000, '0, '0, 0));
      directed_rows.push_back(item_row(CMD_START_READ, 16'h2008, 4'(MAX_WORDS)));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'hBE));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'hEF));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'h92, 1,
                              rx_result(16'hBEEF, 1'b1, STATUS_OK, 1'b0)));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'h00));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'h00));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'h00, 1,
                              rx_result(16'h0000, 1'b0, STATUS_CRC_ERROR, 1'b1)));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'h55, 0));
      directed_rows.push_back(item_row(CMD_START_READ, 16'h1234, 4'd3));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'hFF));
      directed_rows.push_back(item_row(CMD_START_WRITE, 16'hABCD, 4'd1));
      directed_rows.push_back(item_row(CMD_WRITE_DATA, 16'h5555));
      directed_rows.push_back(item_row(CMD_START_READ, 16'hE000, 4'd1));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'hBE));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'hEF));
      directed_rows.push_back(item_row(CMD_RX_BYTE, '0, '0, 8'h92, 1,
                              rx_result(16'hBEEF, 1'b1, STATUS_OK, 1'b1)));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      wait_for_drain();

      // Random part: mostly well-formed frames, some noise and broken frames
      while (effective_items < ITEM_TARGET) begin
         if (effective_items >= ITEM_TARGET - 60) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: run_write_frame();
            4, 5, 6, 7: run_read_frame();
            default:    run_noise();
         endcase
         if ($urandom_range(0, 15) == 0) wait_for_drain();
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d effective items in %0d write and %0d read frames plus noise",
               effective_items, write_frames, read_frames);
      $display("checked %0d results, %0d of them CRC mismatch reports, %0d failures",
               results_checked, crc_error_results, failures);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
